[src/sitl_pkg.sv]
// Shared types and constants for the spiral index to lattice block.
// No dependencies; sitl_ring_map, sitl_scale and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package sitl_pkg;

    localparam int INDEX_W   = 64;
    localparam int LAT_W     = 33;
    localparam int POS_W     = 40;
    localparam int SPACING_W = 8;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 8'd12;

    typedef enum logic [1:0] {
        EDGE_RIGHT,
        EDGE_TOP,
        EDGE_LEFT,
        EDGE_BOTTOM
    } t_edge;

endpackage

`default_nettype wire

[src/sitl_sqrt_step.sv]
// One registered iteration of the bitwise integer square root.
// Standalone; chained by the top level, one instance per root bit.
`timescale 1ns / 1ps
`default_nettype none

module sitl_sqrt_step #(
    parameter int W = 64,
    parameter int J = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [W-1:0] i_rem,
    input  wire logic [W-1:0] i_root,
    output logic              o_valid,
    output logic [W-1:0]      o_rem,
    output logic [W-1:0]      o_root
);

    localparam logic [W:0] PROBE = (W + 1)'(1) << (2 * J);

    logic [W:0]   w_trial;
    logic         w_ge;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_root;
    logic         r_valid;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_root;

    assign w_trial = {1'b0, i_root} + PROBE;
    assign w_ge    = {1'b0, i_rem} >= w_trial;

    always_comb begin
        if (w_ge) begin
            n_rem  = i_rem - w_trial[W-1:0];
            n_root = (i_root >> 1) + PROBE[W-1:0];
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

`default_nettype wire

[src/sitl_ring_map.sv]
// Three-stage map from square root and remainder to a signed lattice point.
// Depends on sitl_pkg for the lattice width and the edge type.
`timescale 1ns / 1ps
`default_nettype none

module sitl_ring_map
    import sitl_pkg::*;
#(
    parameter int ROOT_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [ROOT_W-1:0] i_root,
    input  wire logic [ROOT_W:0]   i_rem,
    output logic                   o_valid,
    output logic signed [LAT_W-1:0] o_lat_x,
    output logic signed [LAT_W-1:0] o_lat_y
);

    localparam int OW = ROOT_W + 3;
    localparam int TW = ROOT_W + 1;

    // Stage A: ring number and offset within the ring.
    logic              n_a_zero;
    logic [ROOT_W-1:0] n_a_ring;
    logic [OW-1:0]     n_a_off;
    logic              r_a_vld;
    logic              r_a_zero;
    logic [ROOT_W-1:0] r_a_ring;
    logic [OW-1:0]     r_a_off;

    assign n_a_zero = (i_root == '0);
    assign n_a_ring = ROOT_W'(({1'b0, i_root} + (ROOT_W + 1)'(1)) >> 1);

    always_comb begin
        if (i_root[0]) begin
            n_a_off = OW'(i_rem);
        end else begin
            n_a_off = OW'(i_rem) + OW'({i_root, 1'b0}) - OW'(1);
        end
    end

    // Stage B: edge selection and position along the edge.
    logic [OW-1:0]     w_e1;
    logic [OW-1:0]     w_e2;
    logic [OW-1:0]     w_e3;
    t_edge             n_b_edge;
    logic [TW-1:0]     n_b_pos;
    logic              r_b_vld;
    logic              r_b_zero;
    logic [ROOT_W-1:0] r_b_ring;
    t_edge             r_b_edge;
    logic [TW-1:0]     r_b_pos;

    assign w_e1 = OW'({r_a_ring, 1'b0});
    assign w_e2 = OW'({r_a_ring, 2'b0});
    assign w_e3 = w_e1 + w_e2;

    always_comb begin
        priority if (r_a_off < w_e1) begin
            n_b_edge = EDGE_RIGHT;
            n_b_pos  = TW'(r_a_off);
        end else if (r_a_off < w_e2) begin
            n_b_edge = EDGE_TOP;
            n_b_pos  = TW'(r_a_off - w_e1);
        end else if (r_a_off < w_e3) begin
            n_b_edge = EDGE_LEFT;
            n_b_pos  = TW'(r_a_off - w_e2);
        end else begin
            n_b_edge = EDGE_BOTTOM;
            n_b_pos  = TW'(r_a_off - w_e3);
        end
    end

    // Stage C: signed lattice coordinates.
    logic signed [LAT_W-1:0] w_sr;
    logic signed [LAT_W-1:0] w_up;
    logic signed [LAT_W-1:0] w_dn;
    logic signed [LAT_W-1:0] n_c_x;
    logic signed [LAT_W-1:0] n_c_y;
    logic                    r_c_vld;
    logic signed [LAT_W-1:0] r_c_x;
    logic signed [LAT_W-1:0] r_c_y;

    assign w_sr = signed'(LAT_W'(r_b_ring));
    assign w_up = signed'(LAT_W'(r_b_pos)) + LAT_W'(1) - w_sr;
    assign w_dn = w_sr - LAT_W'(1) - signed'(LAT_W'(r_b_pos));

    always_comb begin
        unique case (r_b_edge)
            EDGE_RIGHT: begin
                n_c_x = w_sr;
                n_c_y = w_up;
            end
            EDGE_TOP: begin
                n_c_x = w_dn;
                n_c_y = w_sr;
            end
            EDGE_LEFT: begin
                n_c_x = -w_sr;
                n_c_y = w_dn;
            end
            EDGE_BOTTOM: begin
                n_c_x = w_up;
                n_c_y = -w_sr;
            end
            default: begin
                n_c_x = '0;
                n_c_y = '0;
            end
        endcase
        if (r_b_zero) begin
            n_c_x = '0;
            n_c_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_zero <= n_a_zero;
        r_a_ring <= n_a_ring;
        r_a_off  <= n_a_off;
        r_b_zero <= r_a_zero;
        r_b_ring <= r_a_ring;
        r_b_edge <= n_b_edge;
        r_b_pos  <= n_b_pos;
        r_c_x    <= n_c_x;
        r_c_y    <= n_c_y;
    end

    assign o_valid = r_c_vld;
    assign o_lat_x = r_c_x;
    assign o_lat_y = r_c_y;

    a_off_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && !r_a_zero) |-> (r_a_off < {r_a_ring, 3'b000}))
        else $error("ring offset exceeds ring length");

    a_point_on_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && !$past(r_b_zero)) |->
            (r_c_x == $past(w_sr) || r_c_x == -$past(w_sr) ||
             r_c_y == $past(w_sr) || r_c_y == -$past(w_sr)))
        else $error("lattice point does not lie on its ring");

endmodule

`default_nettype wire

[src/sitl_scale.sv]
// Output stage: scales the lattice point by the spacing and registers the result.
// Depends on sitl_pkg for the lattice, position and spacing widths.
`timescale 1ns / 1ps
`default_nettype none

module sitl_scale
    import sitl_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic signed [LAT_W-1:0] i_lat_x,
    input  wire logic signed [LAT_W-1:0] i_lat_y,
    input  wire logic [SPACING_W-1:0]    i_spacing,
    output logic                         o_valid,
    output logic signed [LAT_W-1:0]      o_lat_x,
    output logic signed [LAT_W-1:0]      o_lat_y,
    output logic signed [POS_W-1:0]      o_pos_x,
    output logic signed [POS_W-1:0]      o_pos_y
);

    localparam int PW = LAT_W + SPACING_W + 1;

    logic signed [SPACING_W:0] w_sp;
    logic signed [PW-1:0]      w_px;
    logic signed [PW-1:0]      w_py;
    logic                      r_valid;
    logic signed [LAT_W-1:0]   r_lat_x;
    logic signed [LAT_W-1:0]   r_lat_y;
    logic signed [POS_W-1:0]   r_pos_x;
    logic signed [POS_W-1:0]   r_pos_y;

    assign w_sp = signed'({1'b0, i_spacing});
    assign w_px = i_lat_x * w_sp;
    assign w_py = i_lat_y * w_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lat_x <= i_lat_x;
        r_lat_y <= i_lat_y;
        r_pos_x <= w_px[POS_W-1:0];
        r_pos_y <= w_py[POS_W-1:0];
    end

    assign o_valid = r_valid;
    assign o_lat_x = r_lat_x;
    assign o_lat_y = r_lat_y;
    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;

endmodule

`default_nettype wire

[src/spiral_index_to_lattice_top.sv]
// Channel   Direction  Signals                                     Transfer
// command   in         start, busy, i_index                        start && !busy
// result    out        o_strobe, o_grid_x/y, o_pos_x/y             o_strobe, one cycle
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_data        i_cfg_valid && o_cfg_ready
//
// Top level of the spiral index to lattice block; uses sitl_pkg, sitl_sqrt_step,
// sitl_ring_map and sitl_scale.
// One item can be accepted every cycle while busy is low. The pipeline holds one
// square root stage per root bit, three ring mapping stages and the spacing
// multiply stage.
// The synchronous reset empties the pipeline and loads a spacing of 12; busy is
// high while reset is held and goes low once r_run is set after reset is released.
// The pipeline never stalls, so each result appears on its strobe exactly once.
`timescale 1ns / 1ps
`default_nettype none

module spiral_index_to_lattice_top
    import sitl_pkg::*;
#(
    parameter int INDEX_BITS = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [INDEX_W-1:0]      i_index,
    output logic                         o_strobe,
    output logic signed [LAT_W-1:0]      o_grid_x,
    output logic signed [LAT_W-1:0]      o_grid_y,
    output logic signed [POS_W-1:0]      o_pos_x,
    output logic signed [POS_W-1:0]      o_pos_y,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [SPACING_W-1:0]    i_cfg_data
);

    localparam int K   = (INDEX_BITS + 1) / 2;
    localparam int W   = 2 * K;
    localparam int LAT = K + 4;

    logic                    r_run;
    logic [SPACING_W-1:0]    r_spacing;
    logic                    w_accept;
    logic [K:0]              w_vld;
    logic [W-1:0]            w_rem  [0:K];
    logic [W-1:0]            w_root [0:K];
    logic                    w_map_vld;
    logic signed [LAT_W-1:0] w_map_x;
    logic signed [LAT_W-1:0] w_map_y;

    assign busy        = !r_run;
    assign o_cfg_ready = r_run;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_spacing <= SPACING_RESET;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                r_spacing <= i_cfg_data;
            end
        end
    end

    assign w_vld[0]  = w_accept;
    assign w_rem[0]  = W'(i_index[INDEX_BITS-1:0]);
    assign w_root[0] = '0;

    for (genvar g = 0; g < K; g++) begin : g_sqrt
        sitl_sqrt_step #(
            .W (W),
            .J (K - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .o_valid (w_vld[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1])
        );
    end

    sitl_ring_map #(
        .ROOT_W (K)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vld[K]),
        .i_root  (w_root[K][K-1:0]),
        .i_rem   (w_rem[K][K:0]),
        .o_valid (w_map_vld),
        .o_lat_x (w_map_x),
        .o_lat_y (w_map_y)
    );

    sitl_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_map_vld),
        .i_lat_x   (w_map_x),
        .i_lat_y   (w_map_y),
        .i_spacing (r_spacing),
        .o_valid   (o_strobe),
        .o_lat_x   (o_grid_x),
        .o_lat_y   (o_grid_y),
        .o_pos_x   (o_pos_x),
        .o_pos_y   (o_pos_y)
    );

    a_strobe_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, LAT))
        else $error("result strobe without an accepted item");

    a_zero_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_index[INDEX_BITS-1:0] == '0, LAT)) |->
            (o_grid_x == '0 && o_grid_y == '0 && o_pos_x == '0 && o_pos_y == '0))
        else $error("ordinal zero does not map to the origin");

    a_no_cfg_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_cfg_ready))
        else $error("block ready while coming out of reset");

endmodule

`default_nettype wire
